/* hw/rtl/bptp_pkg.sv */
// ----------------------------------------------------------------------------
// bptp_pkg
// Shared constants and controller/datapath interface types for the
// one-bit pattern tone period estimator.
// ----------------------------------------------------------------------------
package bptp_pkg;

	localparam int SAMPLE_BITS_DEF = 128;
	localparam int POS_W           = 8;
	localparam int CNT_W           = 8;
	localparam int BYTES_W         = 5;
	localparam int PERIOD_W        = 14;
	localparam int NUM_W           = CNT_W + 7;
	localparam int STEP_W          = 4;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

	typedef struct packed {
		logic scan;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last_byte;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

/* hw/rtl/bptp_ctrl.sv */
// ----------------------------------------------------------------------------
// bptp_ctrl
// Sequencer: takes pattern bytes, runs the divider after the final byte and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module bptp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  bptp_pkg::status_t status,
	output bptp_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_TAKE = 3'b001,
		ST_DIV  = 3'b010,
		ST_PUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.scan     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_TAKE: begin
				s_tready = 1'b1;
				cmd.scan = s_tvalid;
				if (s_tvalid && status.last_byte) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_TAKE;
				end
			end
			default: begin
				state_d = ST_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/bptp_dp.sv */
// ----------------------------------------------------------------------------
// bptp_dp
// Datapath: edge scan of one byte per request, restoring divider and the
// output register.
// ----------------------------------------------------------------------------
module bptp_dp #(
	parameter int SAMPLE_BITS = bptp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [7:0]                      s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,
	output logic                            m_tuser,
	input  bptp_pkg::cmd_t                  cmd,
	output bptp_pkg::status_t               status
);

	localparam int PATTERN_BYTES = (SAMPLE_BITS + 7) / 8;
	localparam logic [bptp_pkg::BYTES_W-1:0] LAST_BYTE =
		bptp_pkg::BYTES_W'(PATTERN_BYTES - 1);
	localparam logic [bptp_pkg::POS_W-1:0] START_POS = bptp_pkg::POS_W'(SAMPLE_BITS);

	logic [bptp_pkg::BYTES_W-1:0]  bytes_q;
	logic [bptp_pkg::POS_W-1:0]    last_pos_q;
	logic                          prev_lvl_q;
	logic [bptp_pkg::CNT_W-1:0]    edge_cnt_q;
	logic [bptp_pkg::CNT_W-1:0]    total_q;

	logic [bptp_pkg::POS_W-1:0]    last_pos_n;
	logic                          prev_lvl_n;
	logic [bptp_pkg::CNT_W-1:0]    edge_cnt_n;
	logic [bptp_pkg::CNT_W-1:0]    total_n;

	logic [bptp_pkg::NUM_W-1:0]    num_q;
	logic [bptp_pkg::CNT_W-1:0]    divisor_q;
	logic [bptp_pkg::CNT_W-1:0]    rem_q;
	logic                          zero_q;
	logic [bptp_pkg::STEP_W-1:0]   step_q;
	logic [bptp_pkg::CNT_W:0]      trial;
	logic [bptp_pkg::CNT_W:0]      diff;
	logic                          fits;

	logic                          m_tvalid_q;
	logic [bptp_pkg::PERIOD_W-1:0] period_q;
	logic                          no_edges_q;

	always_comb begin
		logic [bptp_pkg::POS_W-1:0] samp;
		logic [bptp_pkg::POS_W-1:0] pos;
		logic                       lvl;
		prev_lvl_n = prev_lvl_q;
		last_pos_n = last_pos_q;
		edge_cnt_n = edge_cnt_q;
		total_n    = total_q;
		for (int i = 0; i < 8; i++) begin
			samp = bptp_pkg::POS_W'({bytes_q, 3'b000}) + bptp_pkg::POS_W'(i);
			pos  = START_POS - samp;
			lvl  = s_tdata[3'(7 - i)];
			if ((samp < START_POS) && (lvl != prev_lvl_n)) begin
				if (pos != last_pos_n) begin
					total_n    = total_n + (last_pos_n - pos);
					edge_cnt_n = edge_cnt_n + 1'b1;
					last_pos_n = pos;
				end
				prev_lvl_n = lvl;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q    <= '0;
			last_pos_q <= START_POS;
			prev_lvl_q <= 1'b0;
			edge_cnt_q <= '0;
			total_q    <= '0;
		end else if (cmd.scan) begin
			if (bytes_q == LAST_BYTE) begin
				bytes_q    <= '0;
				last_pos_q <= START_POS;
				prev_lvl_q <= 1'b0;
				edge_cnt_q <= '0;
				total_q    <= '0;
			end else begin
				bytes_q    <= bytes_q + 1'b1;
				last_pos_q <= last_pos_n;
				prev_lvl_q <= prev_lvl_n;
				edge_cnt_q <= edge_cnt_n;
				total_q    <= total_n;
			end
		end
	end

	assign trial = {rem_q, num_q[bptp_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk) begin
		if (cmd.scan && (bytes_q == LAST_BYTE)) begin
			num_q     <= {total_n, 7'b0000000};
			divisor_q <= edge_cnt_n;
			zero_q    <= (edge_cnt_n == '0);
			rem_q     <= '0;
			step_q    <= '0;
		end else if (cmd.div_step) begin
			num_q  <= {num_q[bptp_pkg::NUM_W-2:0], fits};
			rem_q  <= fits ? diff[bptp_pkg::CNT_W-1:0] : trial[bptp_pkg::CNT_W-1:0];
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			period_q   <= zero_q ? '0 : num_q[bptp_pkg::PERIOD_W-1:0];
			no_edges_q <= zero_q;
		end
	end

	assign status.last_byte = (bytes_q == LAST_BYTE);
	assign status.div_done  = (step_q == bptp_pkg::LAST_STEP);
	assign status.out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, period_q};
	assign m_tuser  = no_edges_q;

endmodule

/* hw/rtl/bit_pattern_tone_period.sv */
// ----------------------------------------------------------------------------
// bit_pattern_tone_period
// Estimates the tone period of a one-bit audio pattern from its level changes.
// ----------------------------------------------------------------------------
// A pattern of SAMPLE_BITS samples arrives as ceil(SAMPLE_BITS / 8) byte
// requests, most significant bit first, one byte per cycle with no gaps
// needed up to the final byte; s_tready then stays low until the result
// is loaded. Each byte is scanned for level changes in the cycle it is
// taken. After the final byte a restoring divider produces total * 128 /
// edge count at one quotient bit per cycle; the result is placed in the
// output register once it is free. The output register holds a result
// until it is taken while the next pattern streams in. A pattern with no
// counted edge yields period 0 with the no_edges flag set.
// ----------------------------------------------------------------------------
module bit_pattern_tone_period #(
	parameter int SAMPLE_BITS = bptp_pkg::SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pattern_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [13:0] period, [15:14] zero
	output logic        m_tuser    // [0] no_edges
);

	bptp_pkg::cmd_t    cmd;
	bptp_pkg::status_t status;

	bptp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bptp_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.status   (status)
	);

`ifndef SYNTHESIS
	a_flag_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 16'h0000))
		else $error("no_edges result carries a nonzero period");

	a_load_not_taking: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result loaded while byte requests were taken");

	a_div_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && status.last_byte) |=> !s_tready)
		else $error("byte request taken while the divider runs");
`endif

endmodule

/* tb/bit_pattern_tone_period_checker.sv */
// ----------------------------------------------------------------------------
// bit_pattern_tone_period_checker
// Watches both streams of the tone period estimator, predicts the period of
// every complete pattern from the accepted bytes, and compares each accepted
// result with the oldest prediction still due.
// ----------------------------------------------------------------------------
module bit_pattern_tone_period_checker #(
	parameter int SAMPLE_BITS = bptp_pkg::SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pattern_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [13:0] period, [15:14] zero
	input  logic        m_tuser,   // [0] no_edges
	output int          errors,
	output int          tones_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PATTERN_BYTES = (SAMPLE_BITS + 7) / 8;

	typedef struct packed {
		logic [bptp_pkg::PERIOD_W-1:0] period;
		logic                          no_edges;
	} tone_t;

	tone_t      tones_due[$];
	int         error_count = 0;
	logic [4:0] bytes_seen;
	logic [7:0] edge_pos;
	logic       level_now;
	logic [7:0] edge_total;
	logic [7:0] run_sum;

	initial begin
		errors        = 0;
		tones_pending = 0;
	end

	function automatic void clear_pattern();
		bytes_seen = '0;
		edge_pos   = 8'(SAMPLE_BITS);
		level_now  = 1'b0;
		edge_total = '0;
		run_sum    = '0;
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		int    sample;
		int    quot;
		logic  lvl;
		logic [7:0] pos;
		tone_t tone;
		for (int i = 0; i < 8; i++) begin
			sample = int'(bytes_seen) * 8 + i;
			if (sample < SAMPLE_BITS) begin
				pos = 8'(SAMPLE_BITS - sample);
				lvl = b[7 - i];
				if (lvl != level_now) begin
					if (pos != edge_pos) begin
						run_sum    = run_sum + (edge_pos - pos);
						edge_total = edge_total + 8'd1;
						edge_pos   = pos;
					end
					level_now = lvl;
				end
			end
		end
		bytes_seen = bytes_seen + 5'd1;
		if (int'(bytes_seen) >= PATTERN_BYTES) begin
			if (edge_total == 0) begin
				tone.period   = '0;
				tone.no_edges = 1'b1;
			end else begin
				quot          = (int'(run_sum) * 128) / int'(edge_total);
				tone.period   = quot[bptp_pkg::PERIOD_W-1:0];
				tone.no_edges = 1'b0;
			end
			tones_due.push_back(tone);
			clear_pattern();
		end
	endfunction

	always @(posedge clk) begin
		tone_t want;
		if (!arst_n) begin
			clear_pattern();
			tones_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (tones_due.size() == 0) begin
					if (error_count < 10)
						$display("%0t: result with none due: period %0d no_edges %0b",
							$realtime, m_tdata[13:0], m_tuser);
					error_count++;
				end else begin
					want = tones_due.pop_front();
					if (m_tdata[13:0] !== want.period || m_tdata[15:14] !== 2'b00 ||
							m_tuser !== want.no_edges) begin
						if (error_count < 10)
							$display("%0t: tone mismatch: expected period %0d no_edges %0b, got tdata 0x%04h no_edges %0b",
								$realtime, want.period, want.no_edges, m_tdata, m_tuser);
						error_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				take_byte(s_tdata);
		end
		errors        <= error_count;
		tones_pending <= tones_due.size();
	end

endmodule

/* tb/bit_pattern_tone_period_test.sv */
// ----------------------------------------------------------------------------
// bit_pattern_tone_period_test
// Streams directed and random one-bit patterns into the tone period estimator
// under several idle and stall mixes, with a long output hold-off, and reports
// the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module bit_pattern_tone_period_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS     = bptp_pkg::SAMPLE_BITS_DEF;
	localparam int PATTERN_BYTES   = (SAMPLE_BITS + 7) / 8;
	localparam int PHASE_PATTERNS  = 17;
	localparam int LONG_HOLD       = 400;
	localparam int SETTLE_CYCLES   = 48;

	typedef enum int {SHAPE_NOISE, SHAPE_SQUARE, SHAPE_SPARSE, SHAPE_FLAT} shape_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	int          errors;
	int          tones_pending;

	int   send_idle_pct = 0;
	int   stall_pct     = 0;
	logic hold_req      = 1'b0;
	int   idle_mix[4]   = '{0, 73, 0, 31};
	int   stall_mix[4]  = '{0, 0, 73, 31};

	bit_pattern_tone_period #(.SAMPLE_BITS(SAMPLE_BITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	bit_pattern_tone_period_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .tones_pending(tones_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("bit_pattern_tone_period_test: FAIL");
		$finish;
	end

	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				hold_left = LONG_HOLD;
				hold_done = 1;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_pattern(input shape_t shape);
		logic       wave[PATTERN_BYTES * 8];
		logic [7:0] b;
		logic       lvl;
		int         half;
		int         offset;
		lvl    = 1'($urandom_range(1));
		half   = $urandom_range(1, 64);
		offset = $urandom_range(0, 2 * half - 1);
		for (int n = 0; n < PATTERN_BYTES * 8; n++) begin
			case (shape)
				SHAPE_NOISE:  wave[n] = 1'($urandom_range(1));
				SHAPE_SQUARE: wave[n] = lvl ^ 1'(((n + offset) / half) % 2);
				SHAPE_SPARSE: begin
					if ($urandom_range(31) == 0)
						lvl = ~lvl;
					wave[n] = lvl;
				end
				default:      wave[n] = lvl;
			endcase
		end
		for (int k = 0; k < PATTERN_BYTES; k++) begin
			for (int j = 0; j < 8; j++)
				b[7 - j] = wave[k * 8 + j];
			send_byte(b);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tones_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A change at the very first sample only: no edge is counted.
		for (int k = 0; k < PATTERN_BYTES; k++)
			send_byte(8'hFF);
		// First-sample change followed by the densest edges and both extremes.
		send_byte(8'h80);
		for (int k = 1; k < PATTERN_BYTES; k++)
			send_byte((k == PATTERN_BYTES - 1) ? 8'h00 : ((k % 2) ? 8'h55 : 8'hAA));
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = idle_mix[phase];
			stall_pct     = stall_mix[phase];
			if (phase == 0)
				hold_req <= 1'b1;
			for (int p = 0; p < PHASE_PATTERNS; p++) begin
				pick = $urandom_range(9);
				if (pick < 2)
					send_pattern(SHAPE_NOISE);
				else if (pick < 6)
					send_pattern(SHAPE_SQUARE);
				else if (pick < 9)
					send_pattern(SHAPE_SPARSE);
				else
					send_pattern(SHAPE_FLAT);
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && tones_pending == 0)
			$display("bit_pattern_tone_period_test: PASS");
		else
			$display("bit_pattern_tone_period_test: FAIL");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/bptp_pkg.sv
hw/rtl/bptp_ctrl.sv
hw/rtl/bptp_dp.sv
hw/rtl/bit_pattern_tone_period.sv
tb/bit_pattern_tone_period_checker.sv
tb/bit_pattern_tone_period_test.sv
